@@ sv/bpa_pkg.sv @@
package bpa_pkg;

  localparam int unsigned LOG2_PAGES = 10;
  localparam int unsigned NPAGES     = 1 << LOG2_PAGES;
  localparam int unsigned PAGE_W     = 10;
  localparam int unsigned LINK_W     = PAGE_W + 1;
  localparam int unsigned TAG_W      = 5;
  localparam int unsigned LVL_W      = 4;
  localparam int unsigned NLEVELS    = LOG2_PAGES + 1;

  localparam logic [LINK_W-1:0] NULL_LINK  = LINK_W'(NPAGES);
  localparam logic [TAG_W-1:0]  TAG_ALLOC  = 5'd30;
  localparam logic [TAG_W-1:0]  TAG_INSIDE = 5'd31;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RESERVE = 2'd1,
    CMD_FREE    = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_BAD     = 2'd2,
    ST_UNUSED  = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_SEARCH, S_R_RD, S_R_CMP, S_F_RD, S_F_CHK,
    S_F_DN_RD, S_F_DN_CMP, S_F_UP_RD, S_F_UP_CMP, S_SPLIT,
    S_UL_RD, S_UL_W1, S_UL_W2, S_PU1, S_PU2, S_FIN, S_REPLY
  } state_e;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [3:0]        order;
    logic [PAGE_W-1:0] page_index;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [PAGE_W-1:0] result_index;
  } rsp_t;

endpackage

@@ sv/buddy_page_allocator.sv @@
// channel   | ports                    | handshake
// ----------+--------------------------+------------------------------------
// request   | req_i (cmd/order/index)  | taken when start high and busy low
// response  | rsp_o (status/index)     | valid_o high for one cycle, no stall
//
// one request is worked at a time; busy stays high until its response
// an allocate searches the lists level by level, unlinks the block and splits it;
// a reserve reads a tag for each order walked, a free reads a tag per order walked
// down and unlinks and merges each free buddy
// the tag and link memories each have one write port and one registered read port
// after reset a clearing pass over all 1024 pages initializes the tag and link
// memories while busy is high
// the response cannot be stalled: it is shown in the cycle after the work ends
module buddy_page_allocator (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  bpa_pkg::req_t req_i,
  output logic          valid_o,
  output bpa_pkg::rsp_t rsp_o
);
  import bpa_pkg::*;

  state_e              state_q, state_d, ret_q, ret_d;
  logic [1:0]          cmd_q, cmd_d;
  logic [LVL_W-1:0]    ord_q, ord_d, lvl_q, lvl_d, plvl_q, plvl_d;
  logic [PAGE_W-1:0]   idx_q, idx_d, cur_q, cur_d, p_q, p_d, res_q, res_d;
  logic [PAGE_W-1:0]   clr_q, clr_d;
  logic [LINK_W-1:0]   h_q, h_d;
  logic [1:0]          st_q, st_d;
  logic [LINK_W-1:0]   head_q [NLEVELS];
  logic [LINK_W-1:0]   head_d [NLEVELS];

  // memory ports
  logic                tag_we, nxt_we, prv_we;
  logic [PAGE_W-1:0]   tag_wa, nxt_wa, prv_wa, tag_ra, link_ra;
  logic [TAG_W-1:0]    tag_wd, tag_rd;
  logic [LINK_W-1:0]   nxt_wd, prv_wd, nxt_rd, prv_rd;

  logic [PAGE_W-1:0]   bit_lvl, bit_split, cur_split, mask;

  bpa_ram #(.Width(TAG_W), .Depth(NPAGES)) u_tag (
    .clk_i, .we_i(tag_we), .waddr_i(tag_wa), .wdata_i(tag_wd),
    .raddr_i(tag_ra), .rdata_o(tag_rd)
  );
  bpa_ram #(.Width(LINK_W), .Depth(NPAGES)) u_next (
    .clk_i, .we_i(nxt_we), .waddr_i(nxt_wa), .wdata_i(nxt_wd),
    .raddr_i(link_ra), .rdata_o(nxt_rd)
  );
  bpa_ram #(.Width(LINK_W), .Depth(NPAGES)) u_prev (
    .clk_i, .we_i(prv_we), .waddr_i(prv_wa), .wdata_i(prv_wd),
    .raddr_i(link_ra), .rdata_o(prv_rd)
  );

  assign busy    = (state_q != S_IDLE);
  assign valid_o = (state_q == S_REPLY);
  assign rsp_o   = '{status: st_q, result_index: res_q};

  assign bit_lvl   = PAGE_W'(1) << lvl_q;
  assign bit_split = PAGE_W'(1) << (lvl_q - LVL_W'(1));
  // reserve steers toward the requested index, allocate keeps the low half
  assign cur_split = (cmd_q == CMD_RESERVE) ? (cur_q ^ (idx_q & bit_split)) : cur_q;
  assign mask      = ~({PAGE_W{1'b1}} << req_i.order);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      ret_q   <= S_REPLY;
      clr_q   <= '0;
      cmd_q   <= '0;
      ord_q   <= '0;
      lvl_q   <= '0;
      plvl_q  <= '0;
      idx_q   <= '0;
      cur_q   <= '0;
      p_q     <= '0;
      res_q   <= '0;
      h_q     <= NULL_LINK;
      st_q    <= ST_OK;
      for (int i = 0; i < NLEVELS; i++) begin
        head_q[i] <= (i == LOG2_PAGES) ? '0 : NULL_LINK;
      end
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      clr_q   <= clr_d;
      cmd_q   <= cmd_d;
      ord_q   <= ord_d;
      lvl_q   <= lvl_d;
      plvl_q  <= plvl_d;
      idx_q   <= idx_d;
      cur_q   <= cur_d;
      p_q     <= p_d;
      res_q   <= res_d;
      h_q     <= h_d;
      st_q    <= st_d;
      head_q  <= head_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    clr_d   = clr_q;
    cmd_d   = cmd_q;
    ord_d   = ord_q;
    lvl_d   = lvl_q;
    plvl_d  = plvl_q;
    idx_d   = idx_q;
    cur_d   = cur_q;
    p_d     = p_q;
    res_d   = res_q;
    h_d     = h_q;
    st_d    = st_q;
    head_d  = head_q;
    tag_we  = 1'b0;
    tag_wa  = p_q;
    tag_wd  = TAG_INSIDE;
    nxt_we  = 1'b0;
    nxt_wa  = p_q;
    nxt_wd  = NULL_LINK;
    prv_we  = 1'b0;
    prv_wa  = p_q;
    prv_wd  = NULL_LINK;
    tag_ra  = cur_q;
    link_ra = p_q;

    case (state_q)
      // sweep all pages once after reset
      S_CLEAR: begin
        tag_we = 1'b1;
        nxt_we = 1'b1;
        prv_we = 1'b1;
        tag_wa = clr_q;
        nxt_wa = clr_q;
        prv_wa = clr_q;
        tag_wd = (clr_q == '0) ? TAG_W'(LOG2_PAGES) : TAG_INSIDE;
        clr_d  = clr_q + PAGE_W'(1);
        if (clr_q == PAGE_W'(NPAGES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_d = req_i.cmd;
          ord_d = req_i.order;
          idx_d = req_i.page_index;
          cur_d = req_i.page_index;
          lvl_d = req_i.order;
          res_d = '0;
          st_d  = ST_OK;
          case (req_i.cmd)
            CMD_ALLOC: begin
              if (req_i.order > LVL_W'(LOG2_PAGES)) begin
                st_d    = ST_BAD;
                state_d = S_REPLY;
              end else begin
                state_d = S_SEARCH;
              end
            end
            CMD_RESERVE: begin
              if (req_i.order > LVL_W'(LOG2_PAGES) ||
                  (req_i.page_index & mask) != '0) begin
                st_d    = ST_BAD;
                state_d = S_REPLY;
              end else begin
                state_d = S_R_RD;
              end
            end
            CMD_FREE: begin
              state_d = S_F_RD;
            end
            default: begin
              st_d    = ST_BAD;
              state_d = S_REPLY;
            end
          endcase
        end
      end
      // smallest non-empty list at or above the order, one level a cycle
      S_SEARCH: begin
        if (lvl_q > LVL_W'(LOG2_PAGES)) begin
          st_d    = ST_NOSPACE;
          state_d = S_REPLY;
        end else if (head_q[lvl_q] != NULL_LINK) begin
          cur_d   = head_q[lvl_q][PAGE_W-1:0];
          p_d     = head_q[lvl_q][PAGE_W-1:0];
          plvl_d  = lvl_q;
          ret_d   = S_SPLIT;
          state_d = S_UL_RD;
        end else begin
          lvl_d = lvl_q + LVL_W'(1);
        end
      end
      S_R_RD: begin
        tag_ra  = cur_q;
        state_d = S_R_CMP;
      end
      S_R_CMP: begin
        if (tag_rd == TAG_W'(lvl_q)) begin
          p_d     = cur_q;
          plvl_d  = lvl_q;
          ret_d   = S_SPLIT;
          state_d = S_UL_RD;
        end else if (lvl_q >= LVL_W'(LOG2_PAGES)) begin
          st_d    = ST_BAD;
          state_d = S_REPLY;
        end else begin
          cur_d   = cur_q & ~bit_lvl;
          lvl_d   = lvl_q + LVL_W'(1);
          state_d = S_R_RD;
        end
      end
      S_F_RD: begin
        tag_ra  = cur_q;
        state_d = S_F_CHK;
      end
      S_F_CHK: begin
        if (tag_rd != TAG_ALLOC) begin
          st_d    = ST_BAD;
          state_d = S_REPLY;
        end else begin
          tag_we  = 1'b1;
          tag_wa  = cur_q;
          tag_wd  = TAG_INSIDE;
          lvl_d   = '0;
          state_d = S_F_DN_RD;
        end
      end
      // find the order of the block being freed
      S_F_DN_RD: begin
        tag_ra = cur_q ^ bit_lvl;
        if (lvl_q >= LVL_W'(LOG2_PAGES)) begin
          state_d = S_F_UP_RD;
        end else begin
          state_d = S_F_DN_CMP;
        end
      end
      S_F_DN_CMP: begin
        if (tag_rd == TAG_INSIDE) begin
          cur_d   = cur_q & ~bit_lvl;
          lvl_d   = lvl_q + LVL_W'(1);
          state_d = S_F_DN_RD;
        end else begin
          state_d = S_F_UP_RD;
        end
      end
      // merge with free buddies
      S_F_UP_RD: begin
        tag_ra = cur_q ^ bit_lvl;
        if (lvl_q >= LVL_W'(LOG2_PAGES)) begin
          p_d     = cur_q;
          plvl_d  = lvl_q;
          ret_d   = S_REPLY;
          state_d = S_PU1;
        end else begin
          state_d = S_F_UP_CMP;
        end
      end
      S_F_UP_CMP: begin
        if (tag_rd != TAG_W'(lvl_q)) begin
          p_d     = cur_q;
          plvl_d  = lvl_q;
          ret_d   = S_REPLY;
          state_d = S_PU1;
        end else begin
          tag_we  = 1'b1;
          tag_wa  = cur_q ^ bit_lvl;
          tag_wd  = TAG_INSIDE;
          p_d     = cur_q ^ bit_lvl;
          plvl_d  = lvl_q;
          cur_d   = cur_q & ~bit_lvl;
          lvl_d   = lvl_q + LVL_W'(1);
          ret_d   = S_F_UP_RD;
          state_d = S_UL_RD;
        end
      end
      // push the half that is not kept at each split level
      S_SPLIT: begin
        if (lvl_q > ord_q) begin
          cur_d   = cur_split;
          p_d     = cur_split ^ bit_split;
          plvl_d  = lvl_q - LVL_W'(1);
          lvl_d   = lvl_q - LVL_W'(1);
          ret_d   = S_SPLIT;
          state_d = S_PU1;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        tag_we  = 1'b1;
        tag_wa  = cur_q;
        tag_wd  = TAG_ALLOC;
        res_d   = (cmd_q == CMD_ALLOC) ? cur_q : '0;
        state_d = S_REPLY;
      end
      // list unlink of p at plvl
      S_UL_RD: begin
        link_ra = p_q;
        state_d = S_UL_W1;
      end
      S_UL_W1: begin
        if (prv_rd != NULL_LINK) begin
          nxt_we = 1'b1;
          nxt_wa = prv_rd[PAGE_W-1:0];
          nxt_wd = nxt_rd;
        end else begin
          head_d[plvl_q] = nxt_rd;
        end
        if (nxt_rd != NULL_LINK) begin
          prv_we = 1'b1;
          prv_wa = nxt_rd[PAGE_W-1:0];
          prv_wd = prv_rd;
        end
        state_d = S_UL_W2;
      end
      S_UL_W2: begin
        nxt_we  = 1'b1;
        prv_we  = 1'b1;
        state_d = ret_q;
      end
      // list push of p at plvl, tagging it as a free head
      S_PU1: begin
        nxt_we         = 1'b1;
        nxt_wd         = head_q[plvl_q];
        prv_we         = 1'b1;
        tag_we         = 1'b1;
        tag_wd         = TAG_W'(plvl_q);
        h_d            = head_q[plvl_q];
        head_d[plvl_q] = {1'b0, p_q};
        state_d        = S_PU2;
      end
      S_PU2: begin
        if (h_q != NULL_LINK) begin
          prv_we = 1'b1;
          prv_wa = h_q[PAGE_W-1:0];
          prv_wd = {1'b0, p_q};
        end
        state_d = ret_q;
      end
      S_REPLY: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end
endmodule

@@ sv/bpa_ram.sv @@
module bpa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
